FILE: hdl/sequence_pair_packing_evaluator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sequence-pair packing evaluator
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_PAIR_PACKING_EVALUATOR_CORE_ASSERT_SVH
`define SEQUENCE_PAIR_PACKING_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Widths, codes and shared types of the sequence-pair packing evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int MAX_RECTS_DEF = 64;

    localparam int NEG_POS_W = 6;
    localparam int HEIGHT_W  = 24;
    localparam int WIDTH_W   = 8;
    localparam int TIME_W    = 30;
    localparam int WBOUND_W  = 14;

    localparam logic [WBOUND_W-1:0] WBOUND_RST = 14'h3FFF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef struct packed {
        logic [NEG_POS_W-1:0] neg_pos;
        logic [HEIGHT_W-1:0]  height;
        logic [WIDTH_W-1:0]   width;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
        logic pass;
    } t_stair_cmd;

endpackage

FILE: hdl/spe_ifs.sv
// ----------------------------------------------------------------------------
// spe_ifs
// Valid/ready channels of the evaluator: item in, result out, bound write.
// ----------------------------------------------------------------------------
interface spe_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [spe_pkg::NEG_POS_W-1:0]  neg_pos;
    logic [spe_pkg::HEIGHT_W-1:0]   height;
    logic [spe_pkg::WIDTH_W-1:0]    width;
    logic                           last_entry;

    modport source (output valid, func, neg_pos, height, width, last_entry, input ready);
    modport sink   (input valid, func, neg_pos, height, width, last_entry, output ready);
endinterface

interface spe_out_if;
    logic                        valid;
    logic                        ready;
    logic [spe_pkg::TIME_W-1:0]  required_time;
    logic                        width_ok;

    modport source (output valid, required_time, width_ok, input ready);
    modport sink   (input valid, required_time, width_ok, output ready);
endinterface

interface spe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [spe_pkg::WBOUND_W-1:0]  width_bound;

    modport source (output valid, width_bound, input ready);
    modport sink   (input valid, width_bound, output ready);
endinterface

FILE: hdl/spe_entries.sv
// ----------------------------------------------------------------------------
// spe_entries
// Rectangle store: load counter, closed-set flag and the entry memory.
// ----------------------------------------------------------------------------
module spe_entries #(
    parameter int MAX_RECTS = spe_pkg::MAX_RECTS_DEF,
    localparam int IDX_W = $clog2(MAX_RECTS),
    localparam int CNT_W = $clog2(MAX_RECTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_last,
    input  spe_pkg::t_entry   i_entry,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output spe_pkg::t_entry   o_rd_data,
    output logic [CNT_W-1:0]  o_count
);

    logic [CNT_W-1:0] r_count;
    logic             r_closed;
    logic [CNT_W-1:0] w_base;
    logic             w_room;
    spe_pkg::t_entry  r_mem [MAX_RECTS];
    spe_pkg::t_entry  r_rd_data;

    assign w_base = r_closed ? '0 : r_count;
    assign w_room = (w_base < CNT_W'(MAX_RECTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_closed <= 1'b0;
        end else if (i_load) begin
            r_count  <= w_room ? w_base + 1'b1 : w_base;
            r_closed <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && w_room) begin
            r_mem[w_base[IDX_W-1:0]] <= i_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

FILE: hdl/spe_stairs.sv
// ----------------------------------------------------------------------------
// spe_stairs
// Time and width staircase memories with a shared read and write port.
// ----------------------------------------------------------------------------
module spe_stairs #(
    parameter int MAX_RECTS = spe_pkg::MAX_RECTS_DEF,
    localparam int IDX_W = $clog2(MAX_RECTS)
) (
    input  logic                          i_clk,
    input  spe_pkg::t_stair_cmd           i_cmd,
    input  logic [IDX_W-1:0]              i_rd_addr,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  logic [spe_pkg::TIME_W-1:0]    i_wdata,
    output logic [spe_pkg::TIME_W-1:0]    o_time_q,
    output logic [spe_pkg::WBOUND_W-1:0]  o_width_q
);

    logic [spe_pkg::TIME_W-1:0]   r_time_mem  [MAX_RECTS];
    logic [spe_pkg::WBOUND_W-1:0] r_width_mem [MAX_RECTS];
    logic [spe_pkg::TIME_W-1:0]   r_time_q;
    logic [spe_pkg::WBOUND_W-1:0] r_width_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (i_cmd.clear || !i_cmd.pass)) begin
            r_time_mem[i_wr_addr] <= i_cmd.clear ? '0 : i_wdata;
        end
        if (i_cmd.wr_en && (i_cmd.clear || i_cmd.pass)) begin
            r_width_mem[i_wr_addr] <= i_cmd.clear ? '0 : i_wdata[spe_pkg::WBOUND_W-1:0];
        end
        if (i_cmd.rd_en) begin
            r_time_q  <= r_time_mem[i_rd_addr];
            r_width_q <= r_width_mem[i_rd_addr];
        end
    end

    assign o_time_q  = r_time_q;
    assign o_width_q = r_width_q;

endmodule

FILE: hdl/spe_seq.sv
// ----------------------------------------------------------------------------
// spe_seq
// Sequencer with the shared adder and comparator: clear sweep, forward time
// pass, reverse width pass, result register and the width bound register.
// ----------------------------------------------------------------------------
module spe_seq #(
    parameter int MAX_RECTS = spe_pkg::MAX_RECTS_DEF,
    localparam int IDX_W = $clog2(MAX_RECTS),
    localparam int CNT_W = $clog2(MAX_RECTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_eval,
    output logic                          o_in_ready,
    input  logic                          i_cfg_wr,
    input  logic [spe_pkg::WBOUND_W-1:0]  i_cfg_data,
    input  logic [CNT_W-1:0]              i_count,
    output logic                          o_ent_rd_en,
    output logic [IDX_W-1:0]              o_ent_addr,
    input  spe_pkg::t_entry               i_ent,
    output spe_pkg::t_stair_cmd           o_st_cmd,
    output logic [IDX_W-1:0]              o_st_rd_addr,
    output logic [IDX_W-1:0]              o_st_wr_addr,
    output logic [spe_pkg::TIME_W-1:0]    o_st_wdata,
    input  logic [spe_pkg::TIME_W-1:0]    i_st_time,
    input  logic [spe_pkg::WBOUND_W-1:0]  i_st_width,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spe_pkg::TIME_W-1:0]    o_required_time,
    output logic                          o_width_ok
);

    localparam int P_W   = (CNT_W > spe_pkg::NEG_POS_W) ? CNT_W : spe_pkg::NEG_POS_W;
    localparam int SUM_W = spe_pkg::TIME_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_ENT   = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_TCAP  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                   r_state, n_state;
    logic                         r_pass, n_pass;
    logic [CNT_W-1:0]             r_n, n_n;
    logic [IDX_W-1:0]             r_i, n_i;
    logic [IDX_W-1:0]             r_j, n_j;
    logic [spe_pkg::TIME_W-1:0]   r_v, n_v;
    logic [spe_pkg::TIME_W-1:0]   r_time, n_time;
    logic                         r_ok, n_ok;
    logic                         r_out_valid, n_out_valid;
    logic [spe_pkg::TIME_W-1:0]   r_out_time, n_out_time;
    logic                         r_out_ok, n_out_ok;
    logic [spe_pkg::WBOUND_W-1:0] r_width_bound;

    logic [P_W-1:0]               w_p;
    logic                         w_pin;
    logic                         w_last_i;
    logic                         w_last_j;
    logic [SUM_W-1:0]             w_add_a;
    logic [SUM_W-1:0]             w_add_b;
    logic [SUM_W-1:0]             w_sum;
    logic [spe_pkg::TIME_W-1:0]   w_v;
    logic                         w_over;
    logic [spe_pkg::TIME_W-1:0]   w_d;
    logic                         w_gt;
    logic [3:0]                   w_adv_state;
    logic [IDX_W-1:0]             w_adv_i;

    // shared adder and comparators
    assign w_p      = P_W'(i_ent.neg_pos);
    assign w_pin    = (w_p < P_W'(r_n));
    assign w_last_i = ((CNT_W'(r_i) + 1'b1) == r_n);
    assign w_last_j = ((CNT_W'(r_j) + 1'b1) == r_n);
    assign w_add_a  = !w_pin ? '0 : (r_pass ? SUM_W'(i_st_width) : SUM_W'(i_st_time));
    assign w_add_b  = r_pass ? SUM_W'(i_ent.width) : SUM_W'(i_ent.height);
    assign w_sum    = w_add_a + w_add_b;
    assign w_v      = (!r_pass && w_sum[SUM_W-1]) ? '1 : w_sum[spe_pkg::TIME_W-1:0];
    assign w_over   = (w_sum > SUM_W'(r_width_bound));
    assign w_d      = r_pass ? spe_pkg::TIME_W'(i_st_width) : i_st_time;
    assign w_gt     = (r_v > w_d);

    always_comb begin
        if (!r_pass) begin
            w_adv_state = w_last_i ? S_FIN : S_ENT;
            w_adv_i     = r_i + 1'b1;
        end else begin
            w_adv_state = (r_i == '0) ? S_DONE : S_ENT;
            w_adv_i     = r_i - 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pass       = r_pass;
        n_n          = r_n;
        n_i          = r_i;
        n_j          = r_j;
        n_v          = r_v;
        n_time       = r_time;
        n_ok         = r_ok;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_time   = r_out_time;
        n_out_ok     = r_out_ok;
        o_ent_rd_en  = 1'b0;
        o_ent_addr   = r_i;
        o_st_cmd     = '0;
        o_st_cmd.pass = r_pass;
        o_st_rd_addr = r_j;
        o_st_wr_addr = r_j;
        o_st_wdata   = r_v;
        case (r_state)
            S_IDLE: begin
                if (i_eval) begin
                    n_pass = 1'b0;
                    n_ok   = 1'b1;
                    n_n    = i_count;
                    n_j    = '0;
                    if (i_count == '0) begin
                        n_time  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_st_cmd.wr_en = 1'b1;
                o_st_cmd.clear = 1'b1;
                if (w_last_j) begin
                    n_i     = '0;
                    n_state = S_ENT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_ENT: begin
                o_ent_rd_en = 1'b1;
                n_state     = S_BASE;
            end
            S_BASE: begin
                o_st_cmd.rd_en = w_pin;
                o_st_rd_addr   = IDX_W'(w_p);
                n_state        = S_ADD;
            end
            S_ADD: begin
                if (r_pass && w_over) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_v = w_v;
                    if (w_pin) begin
                        n_j     = IDX_W'(w_p);
                        n_state = S_WALK;
                    end else begin
                        n_i     = w_adv_i;
                        n_state = w_adv_state;
                    end
                end
            end
            S_WALK: begin
                if (w_gt) begin
                    o_st_cmd.wr_en = 1'b1;
                    if (w_last_j) begin
                        n_i     = w_adv_i;
                        n_state = w_adv_state;
                    end else begin
                        o_st_cmd.rd_en = 1'b1;
                        o_st_rd_addr   = r_j + 1'b1;
                        n_j            = r_j + 1'b1;
                    end
                end else begin
                    n_i     = w_adv_i;
                    n_state = w_adv_state;
                end
            end
            S_FIN: begin
                o_st_cmd.rd_en = 1'b1;
                o_st_rd_addr   = IDX_W'(r_n - 1'b1);
                n_state        = S_TCAP;
            end
            S_TCAP: begin
                n_time  = i_st_time;
                n_pass  = 1'b1;
                n_i     = IDX_W'(r_n - 1'b1);
                n_state = S_ENT;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_time;
                    n_out_ok    = r_ok;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_width_bound <= spe_pkg::WBOUND_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr) begin
                r_width_bound <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass     <= n_pass;
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_v        <= n_v;
        r_time     <= n_time;
        r_ok       <= n_ok;
        r_out_time <= n_out_time;
        r_out_ok   <= n_out_ok;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_required_time = r_out_time;
    assign o_width_ok      = r_out_ok;

`include "sequence_pair_packing_evaluator_core_assert.svh"

    `SPE_ASSERT_IMPL(a_walk_in_set, r_state == S_WALK, CNT_W'(r_j) < r_n, "walk index beyond set")
    `SPE_ASSERT_IMPL(a_clear_nonempty, r_state == S_CLEAR, r_n != '0, "clear sweep on empty set")
    `SPE_ASSERT_IMPL(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "result not from done")
    `SPE_ASSERT_NEXT(a_walk_stop, (r_state == S_WALK) && !w_gt, (r_state == S_ENT) || (r_state == S_FIN) || (r_state == S_DONE), "walk did not stop")

endmodule

FILE: hdl/sequence_pair_packing_evaluator_core.sv
// ----------------------------------------------------------------------------
// sequence_pair_packing_evaluator_core
// Loads rectangles, then packs them with a forward time staircase and a
// reverse width staircase; one result per evaluate transfer.
// Load transfer: accepted back to back while idle; no result.
// Evaluate with n entries: clear sweep of n entries, then per rectangle and pass
// entry read, base read, add and staircase walk; time capture after forward pass.
// Empty set: straight to the done state, zero time. One item at a time.
// Reset clears the sequencer, count and output valid; bound resets to 16383.
// ----------------------------------------------------------------------------
module sequence_pair_packing_evaluator_core #(
    parameter int MAX_RECTS = spe_pkg::MAX_RECTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spe_in_if.sink     i_in,
    spe_out_if.source  o_out,
    spe_cfg_if.sink    i_cfg
);

    localparam int IDX_W = $clog2(MAX_RECTS);
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    logic                          w_ready;
    logic                          w_xfer;
    spe_pkg::t_entry               w_entry;
    spe_pkg::t_entry               w_ent_q;
    logic [CNT_W-1:0]              w_count;
    logic                          w_ent_rd_en;
    logic [IDX_W-1:0]              w_ent_addr;
    spe_pkg::t_stair_cmd           w_st_cmd;
    logic [IDX_W-1:0]              w_st_rd_addr;
    logic [IDX_W-1:0]              w_st_wr_addr;
    logic [spe_pkg::TIME_W-1:0]    w_st_wdata;
    logic [spe_pkg::TIME_W-1:0]    w_st_time;
    logic [spe_pkg::WBOUND_W-1:0]  w_st_width;

    assign w_xfer          = i_in.valid && w_ready;
    assign w_entry.neg_pos = i_in.neg_pos;
    assign w_entry.height  = i_in.height;
    assign w_entry.width   = i_in.width;
    assign i_in.ready      = w_ready;
    assign i_cfg.ready     = 1'b1;

    spe_entries #(.MAX_RECTS(MAX_RECTS)) u_entries (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_xfer && (i_in.func == spe_pkg::FUNC_LOAD)),
        .i_last    (i_in.last_entry),
        .i_entry   (w_entry),
        .i_rd_en   (w_ent_rd_en),
        .i_rd_addr (w_ent_addr),
        .o_rd_data (w_ent_q),
        .o_count   (w_count)
    );

    spe_stairs #(.MAX_RECTS(MAX_RECTS)) u_stairs (
        .i_clk     (i_clk),
        .i_cmd     (w_st_cmd),
        .i_rd_addr (w_st_rd_addr),
        .i_wr_addr (w_st_wr_addr),
        .i_wdata   (w_st_wdata),
        .o_time_q  (w_st_time),
        .o_width_q (w_st_width)
    );

    spe_seq #(.MAX_RECTS(MAX_RECTS)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_eval          (w_xfer && (i_in.func == spe_pkg::FUNC_EVAL)),
        .o_in_ready      (w_ready),
        .i_cfg_wr        (i_cfg.valid),
        .i_cfg_data      (i_cfg.width_bound),
        .i_count         (w_count),
        .o_ent_rd_en     (w_ent_rd_en),
        .o_ent_addr      (w_ent_addr),
        .i_ent           (w_ent_q),
        .o_st_cmd        (w_st_cmd),
        .o_st_rd_addr    (w_st_rd_addr),
        .o_st_wr_addr    (w_st_wr_addr),
        .o_st_wdata      (w_st_wdata),
        .i_st_time       (w_st_time),
        .i_st_width      (w_st_width),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_required_time (o_out.required_time),
        .o_width_ok      (o_out.width_ok)
    );

endmodule

FILE: dv/tb_sequence_pair_packing_evaluator_core.sv
// ----------------------------------------------------------------------------
// tb_sequence_pair_packing_evaluator_core
// Loads rectangle sets through the item channel and evaluates them. Each
// accepted evaluate is packed by a local staircase predictor. Every returned
// result is compared with the oldest predicted one. Directed cases cover the
// empty set, single and open sets, full capacity with overflow, and width
// bound edges. Random sets, mostly permutations, follow under several bounds
// with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sequence_pair_packing_evaluator_core;

    localparam int     MAX_RECTS     = spe_pkg::MAX_RECTS_DEF;
    localparam int     NEG_POS_W     = spe_pkg::NEG_POS_W;
    localparam int     HEIGHT_W      = spe_pkg::HEIGHT_W;
    localparam int     WIDTH_W       = spe_pkg::WIDTH_W;
    localparam int     TIME_W        = spe_pkg::TIME_W;
    localparam int     WBOUND_W      = spe_pkg::WBOUND_W;
    localparam int     ITEM_TARGET   = 1450;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 100;
    localparam int     QUIET_LIMIT   = 40000;
    localparam longint TIME_SAT      = (longint'(1) << TIME_W) - 1;

    typedef struct {
        logic [TIME_W-1:0] req_time;
        logic              width_ok;
    } t_pack_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spe_in_if  in_ch ();
    spe_out_if res_ch ();
    spe_cfg_if cfg_ch ();

    sequence_pair_packing_evaluator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    spe_pkg::t_entry shadow_entry [MAX_RECTS];
    int              shadow_count;
    bit              shadow_closed;
    int              shadow_bound;
    t_pack_result    pending_pack [$];
    int              mismatch_count;
    int              items_sent;
    int              quiet_cycles;
    bit              no_idle;

    function automatic t_pack_result predict_packing();
        t_pack_result res;
        longint       tstair [MAX_RECTS];
        int           wstair [MAX_RECTS];
        int           n;
        int           p;
        int           j;
        int           k;
        longint       tv;
        int           wv;
        bit           stop;
        n = shadow_count;
        for (j = 0; j < MAX_RECTS; j++) begin
            tstair[j] = 0;
            wstair[j] = 0;
        end
        for (k = 0; k < n; k++) begin
            p  = int'(shadow_entry[k].neg_pos);
            tv = (p < n) ? tstair[p] : 0;
            tv = tv + shadow_entry[k].height;
            if (tv > TIME_SAT) tv = TIME_SAT;
            for (j = p; j < n; j++) begin
                if (tv > tstair[j]) tstair[j] = tv;
                else break;
            end
        end
        res.req_time = (n == 0) ? '0 : tstair[n-1][TIME_W-1:0];
        res.width_ok = 1'b1;
        stop = 1'b0;
        for (k = n - 1; k >= 0 && !stop; k--) begin
            p  = int'(shadow_entry[k].neg_pos);
            wv = (p < n) ? wstair[p] : 0;
            wv = wv + int'(shadow_entry[k].width);
            if (wv > shadow_bound) begin
                res.width_ok = 1'b0;
                stop = 1'b1;
            end else begin
                for (j = p; j < n; j++) begin
                    if (wv > wstair[j]) wstair[j] = wv;
                    else break;
                end
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic func, input spe_pkg::t_entry e, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.neg_pos    <= e.neg_pos;
        in_ch.height     <= e.height;
        in_ch.width      <= e.width;
        in_ch.last_entry <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (func == spe_pkg::FUNC_LOAD) begin
            if (shadow_closed) begin
                shadow_count  = 0;
                shadow_closed = 1'b0;
            end
            if (shadow_count < MAX_RECTS) begin
                shadow_entry[shadow_count] = e;
                shadow_count++;
            end
            if (last) shadow_closed = 1'b1;
        end else begin
            pending_pack.push_back(predict_packing());
        end
    endtask

    task automatic load_rect(input int p, input logic [HEIGHT_W-1:0] h,
                             input logic [WIDTH_W-1:0] w, input logic last);
        spe_pkg::t_entry e;
        e.neg_pos = p[NEG_POS_W-1:0];
        e.height  = h;
        e.width   = w;
        send_item(spe_pkg::FUNC_LOAD, e, last);
    endtask

    task automatic evaluate();
        spe_pkg::t_entry noise;
        noise.neg_pos = NEG_POS_W'($urandom_range(0, 63));
        noise.height  = HEIGHT_W'($urandom());
        noise.width   = WIDTH_W'($urandom());
        send_item(spe_pkg::FUNC_EVAL, noise, ($urandom_range(0, 1) == 1));
    endtask

    task automatic in_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_idle();
        while (pending_pack.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [WBOUND_W-1:0] bound);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.width_bound <= bound;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow_bound = int'(bound);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return HEIGHT_W'($urandom_range(0, 255));
            default: return HEIGHT_W'($urandom());
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return WIDTH_W'($urandom());
        endcase
    endfunction

    function automatic logic [WBOUND_W-1:0] pick_bound();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return spe_pkg::WBOUND_RST;
            2:       return WBOUND_W'($urandom_range(0, 16383));
            3:       return WBOUND_W'($urandom_range(0, 1023));
            default: return WBOUND_W'($urandom_range(150, 900));
        endcase
    endfunction

    task automatic test_empty_set();
        evaluate();
        evaluate();
    endtask

    task automatic test_small_sets();
        load_rect(0, '1, '1, 1'b1);
        evaluate();
        load_rect(63, '1, '1, 1'b1);
        evaluate();
        load_rect(1, '0, '0, 1'b0);
        load_rect(0, '0, '0, 1'b1);
        evaluate();
        // open set keeps growing across an evaluate
        load_rect(1, 24'd1000, 8'd17, 1'b0);
        evaluate();
        load_rect(0, 24'd250, 8'd3, 1'b1);
        evaluate();
        evaluate();
        load_rect(0, 24'd7, 8'd200, 1'b0);
        load_rect(0, 24'd9, 8'd100, 1'b0);
        load_rect(0, 24'd11, 8'd50, 1'b1);
        evaluate();
    endtask

    task automatic test_full_capacity();
        int i;
        for (i = 0; i < MAX_RECTS; i++) load_rect(i, '1, '1, i == MAX_RECTS - 1);
        evaluate();
        // drop loads past capacity, keep their last mark
        for (i = 0; i < MAX_RECTS; i++) load_rect(i, pick_height(), pick_width(), 1'b0);
        load_rect(0, '1, '1, 1'b0);
        load_rect(5, '1, '1, 1'b1);
        evaluate();
        evaluate();
        load_rect(0, 24'd42, 8'd5, 1'b1);
        evaluate();
    endtask

    task automatic test_width_bound_edges();
        int i;
        wait_idle();
        for (i = 0; i < MAX_RECTS; i++) load_rect(MAX_RECTS - 1 - i, '1, '1, i == MAX_RECTS - 1);
        evaluate();
        wait_idle();
        cfg_write(14'd16319);
        evaluate();
        wait_idle();
        cfg_write(14'd16320);
        evaluate();
        wait_idle();
        cfg_write('0);
        evaluate();
        load_rect(2, 24'd3, '0, 1'b0);
        load_rect(1, 24'd2, '0, 1'b0);
        load_rect(0, 24'd1, '0, 1'b1);
        evaluate();
        wait_idle();
        cfg_write(spe_pkg::WBOUND_RST);
        evaluate();
    endtask

    task automatic random_set();
        int   perm [MAX_RECTS];
        int   n;
        int   m;
        int   kind;
        int   mid_eval;
        int   evals;
        int   i;
        int   j;
        int   tmp;
        int   p;
        logic last;
        n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(9, MAX_RECTS + 2))
                                         : int'($urandom_range(1, 8));
        m = (n < MAX_RECTS) ? n : MAX_RECTS;
        for (i = 0; i < m; i++) perm[i] = i;
        for (i = m - 1; i > 0; i--) begin
            j       = int'($urandom_range(0, i));
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        kind     = int'($urandom_range(0, 99));
        mid_eval = (kind >= 80) ? int'($urandom_range(0, n)) : -1;
        for (i = 0; i < n; i++) begin
            if (i == mid_eval) evaluate();
            if (kind < 80) p = (i < MAX_RECTS) ? perm[i] : int'($urandom_range(0, 63));
            else if (kind < 90) p = int'($urandom_range(0, 63));
            else p = int'($urandom_range(0, n));
            last = (i == n - 1) && (kind < 95);
            load_rect(p, pick_height(), pick_width(), last);
        end
        evals = (kind < 95) ? int'($urandom_range(1, 2)) : int'($urandom_range(0, 1));
        repeat (evals) evaluate();
    endtask

    task automatic test_random_sets();
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            cfg_write(pick_bound());
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (12) begin
                random_set();
                if ($urandom_range(0, 9) == 0) wait_idle();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_monitor
        int           stall;
        t_pack_result want;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : int'($urandom_range(0, 3));
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if (pending_pack.size() == 0) begin
                $display("%0t unexpected result: expected none, actual time %0d ok %0d",
                         $time, res_ch.required_time, res_ch.width_ok);
                mismatch_count++;
            end else begin
                want = pending_pack.pop_front();
                if (res_ch.required_time !== want.req_time) begin
                    $display("%0t required_time mismatch: expected %0d, actual %0d",
                             $time, want.req_time, res_ch.required_time);
                    mismatch_count++;
                end
                if (res_ch.width_ok !== want.width_ok) begin
                    $display("%0t width_ok mismatch: expected %0d, actual %0d",
                             $time, want.width_ok, res_ch.width_ok);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        shadow_count   = 0;
        shadow_closed  = 1'b0;
        shadow_bound   = int'(spe_pkg::WBOUND_RST);
        mismatch_count = 0;
        items_sent     = 0;
        quiet_cycles   = 0;
        no_idle        = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= spe_pkg::FUNC_LOAD;
        in_ch.neg_pos      <= '0;
        in_ch.height       <= '0;
        in_ch.width        <= '0;
        in_ch.last_entry   <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.width_bound <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_set();
        test_small_sets();
        test_full_capacity();
        test_width_bound_edges();
        test_random_sets();

        in_idle();
        while (pending_pack.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pack.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
